FILE: rtl/cbez_pkg.sv
// Shared constants and types for the cubic Bezier evaluate-and-split pipeline.
package cbez_pkg;

  localparam int POS_W   = 17;
  localparam int HGT_W   = 32;
  localparam int DER_W   = 38;
  localparam int CFG_A_W = 2;
  localparam int IN_TD_W = 24;
  localparam int OUT_TD_W = 240;

  localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_START_HEIGHT   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_FIRST_CONTROL  = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_SECOND_CONTROL = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_END_HEIGHT     = 2'd3;

  typedef logic signed [HGT_W-1:0] hgt_t;
  typedef logic signed [DER_W-1:0] der_t;
  typedef logic [POS_W-1:0]        pos_t;

endpackage

FILE: rtl/cubic_bezier_eval_and_split.sv
// Cubic Bezier vertical curve: height, derivatives and de Casteljau split, pipelined.
//
// Usage:
//  - Configure the four control heights (signed Q15.16) through cfg_we/cfg_addr/cfg_wdata
//    while the pipeline is empty: 0 start_height, 1 first_control, 2 second_control,
//    3 end_height. Reset clears all four to zero.
//  - in_* carries one request per position (unsigned Q1.16, values above 1.0 clamp to 1.0).
//  - out_* returns one result per request, in order: height, slope, curvature and the
//    inner control points of the left and right halves.
//  - Acceptance to out_tvalid spans seven register stages; throughput is one request per cycle
//    unless out_tready stalls. De Casteljau levels one and two each cost one stage of 17-bit
//    multipliers; level three's 65-bit difference uses two partial products over two stages.
//  - Every stage carries its own valid bit. When out_tready is low only full stages
//    hold, so bubbles close up and in_tready stays high until all seven stages are full.
//  - Reset (synchronous, active low) empties the pipeline; in-flight requests are dropped.
//  - All outputs are exact up to one round to nearest, ties up, at the last stage of each.
module cubic_bezier_eval_and_split (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [cbez_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [cbez_pkg::HGT_W-1:0]      cfg_wdata,
  // request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cbez_pkg::IN_TD_W-1:0]    in_tdata,   // [16:0] position, [23:17] zero
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cbez_pkg::OUT_TD_W-1:0]   out_tdata   // [31:0] height, [69:32] slope,
                                                      // [107:70] curvature,
                                                      // [139:108] left_inner_first,
                                                      // [171:140] left_inner_second,
                                                      // [203:172] right_inner_first,
                                                      // [235:204] right_inner_second,
                                                      // [239:236] zero
);
  import cbez_pkg::*;

  // control heights and their first differences
  hgt_t a_r, b_r, c_r, d_r;
  logic signed [32:0] d_ba_r, d_cb_r, d_dc_r;

  // stage valids and advance enables
  logic [6:0] v_r;
  logic [6:0] en;

  // stage 1: clamped position
  pos_t p1_r;
  pos_t p_sat;

  // stage 2: first level, Q.32
  logic signed [47:0] l1ab_r, l1bc_r, l1cd_r;
  pos_t p2_r;
  logic signed [50:0] m1ab, m1bc, m1cd;
  logic signed [50:0] s1ab, s1bc, s1cd;

  // stage 3: level-one differences, curvature sum, outer split points
  logic signed [48:0] e_ab_r, e_bc_r;
  logic signed [47:0] l1ab3_r, l1bc3_r;
  logic signed [49:0] c3_r;
  hgt_t lif3_r, ris3_r;
  pos_t p3_r;
  logic signed [48:0] lif_sum, ris_sum;

  // stage 4: second level, Q.48
  logic signed [63:0] l2abc_r, l2bcd_r;
  der_t curv4_r;
  hgt_t lif4_r, ris4_r;
  pos_t p4_r;
  logic signed [66:0] m2abc, m2bcd, s2abc, s2bcd;
  logic signed [53:0] curv_sum;

  // stage 5: second-level difference, inner split points
  logic signed [64:0] f5_r;
  logic signed [63:0] l2abc5_r;
  der_t curv5_r;
  hgt_t lif5_r, ris5_r, lis5_r, rif5_r;
  pos_t p5_r;
  logic signed [64:0] lis_sum, rif_sum;

  // stage 6: partial products of the last level, slope
  logic [48:0]        plo6_r;
  logic signed [50:0] phi6_r;
  logic signed [63:0] l2abc6_r;
  der_t slope6_r, curv6_r;
  hgt_t lif6_r, ris6_r, lis6_r, rif6_r;
  logic signed [69:0] slope_sum;

  // stage 7: output register
  hgt_t height7_r, lif7_r, ris7_r, lis7_r, rif7_r;
  der_t slope7_r, curv7_r;
  logic signed [83:0] h_sum;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_HEIGHT:   a_r <= cfg_wdata;
        REG_FIRST_CONTROL:  b_r <= cfg_wdata;
        REG_SECOND_CONTROL: c_r <= cfg_wdata;
        REG_END_HEIGHT:     d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // registered differences; the user must make config changes only when idle, unenforced
  always_ff @(posedge clk) begin
    d_ba_r <= {b_r[31], b_r} - {a_r[31], a_r};
    d_cb_r <= {c_r[31], c_r} - {b_r[31], b_r};
    d_dc_r <= {d_r[31], d_r} - {c_r[31], c_r};
  end

  // ---------------------------------------------------------------- flow control
  // a stage advances when it is empty or the stage after it advances
  assign en[6] = ~v_r[6] | out_tready;
  assign en[5] = ~v_r[5] | en[6];
  assign en[4] = ~v_r[4] | en[5];
  assign en[3] = ~v_r[3] | en[4];
  assign en[2] = ~v_r[2] | en[3];
  assign en[1] = ~v_r[1] | en[2];
  assign en[0] = ~v_r[0] | en[1];

  assign in_tready  = en[0];
  assign out_tvalid = v_r[6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
      if (en[4]) v_r[4] <= v_r[3];
      if (en[5]) v_r[5] <= v_r[4];
      if (en[6]) v_r[6] <= v_r[5];
    end
  end

  // ---------------------------------------------------------------- stage 1
  assign p_sat = (in_tdata[POS_W-1:0] > POS_ONE) ? POS_ONE : in_tdata[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) p1_r <= p_sat;
  end

  // ---------------------------------------------------------------- stage 2
  // a*q + b*p = a*2^16 + (b-a)*p
  always_comb begin
    m1ab = d_ba_r * $signed({1'b0, p1_r});
    m1bc = d_cb_r * $signed({1'b0, p1_r});
    m1cd = d_dc_r * $signed({1'b0, p1_r});
    s1ab = $signed({{3{a_r[31]}}, a_r, 16'h0}) + m1ab;
    s1bc = $signed({{3{b_r[31]}}, b_r, 16'h0}) + m1bc;
    s1cd = $signed({{3{c_r[31]}}, c_r, 16'h0}) + m1cd;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      l1ab_r <= s1ab[47:0];
      l1bc_r <= s1bc[47:0];
      l1cd_r <= s1cd[47:0];
      p2_r   <= p1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  assign lif_sum = {l1ab_r[47], l1ab_r} + 49'sh8000;
  assign ris_sum = {l1cd_r[47], l1cd_r} + 49'sh8000;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      e_ab_r  <= {l1bc_r[47], l1bc_r} - {l1ab_r[47], l1ab_r};
      e_bc_r  <= {l1cd_r[47], l1cd_r} - {l1bc_r[47], l1bc_r};
      // second difference: (a-2b+c)q + (b-2c+d)p
      c3_r    <= {{2{l1ab_r[47]}}, l1ab_r} - {l1bc_r[47], l1bc_r, 1'b0}
                 + {{2{l1cd_r[47]}}, l1cd_r};
      l1ab3_r <= l1ab_r;
      l1bc3_r <= l1bc_r;
      lif3_r  <= lif_sum[47:16];
      ris3_r  <= ris_sum[47:16];
      p3_r    <= p2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  always_comb begin
    m2abc    = e_ab_r * $signed({1'b0, p3_r});
    m2bcd    = e_bc_r * $signed({1'b0, p3_r});
    s2abc    = $signed({{3{l1ab3_r[47]}}, l1ab3_r, 16'h0}) + m2abc;
    s2bcd    = $signed({{3{l1bc3_r[47]}}, l1bc3_r, 16'h0}) + m2bcd;
    // 6x = 4x + 2x, then round off 16 bits
    curv_sum = $signed({{2{c3_r[49]}}, c3_r, 2'b00}) + $signed({{3{c3_r[49]}}, c3_r, 1'b0})
               + 54'sh8000;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      l2abc_r <= s2abc[63:0];
      l2bcd_r <= s2bcd[63:0];
      curv4_r <= curv_sum[53:16];
      lif4_r  <= lif3_r;
      ris4_r  <= ris3_r;
      p4_r    <= p3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  assign lis_sum = {l2abc_r[63], l2abc_r} + 65'sh8000_0000;
  assign rif_sum = {l2bcd_r[63], l2bcd_r} + 65'sh8000_0000;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      f5_r     <= {l2bcd_r[63], l2bcd_r} - {l2abc_r[63], l2abc_r};
      l2abc5_r <= l2abc_r;
      curv5_r  <= curv4_r;
      lif5_r   <= lif4_r;
      ris5_r   <= ris4_r;
      lis5_r   <= lis_sum[63:32];
      rif5_r   <= rif_sum[63:32];
      p5_r     <= p4_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // slope = 3 * (L2bcd - L2abc), rounded off 32 bits
  assign slope_sum = $signed({{4{f5_r[64]}}, f5_r, 1'b0}) + $signed({{5{f5_r[64]}}, f5_r})
                     + 70'sh8000_0000;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      plo6_r    <= f5_r[31:0] * p5_r;
      phi6_r    <= $signed(f5_r[64:32]) * $signed({1'b0, p5_r});
      l2abc6_r  <= l2abc5_r;
      slope6_r  <= slope_sum[69:32];
      curv6_r   <= curv5_r;
      lif6_r    <= lif5_r;
      ris6_r    <= ris5_r;
      lis6_r    <= lis5_r;
      rif6_r    <= rif5_r;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // height = L2abc*2^16 + (L2bcd-L2abc)*p, rounded off 48 bits
  assign h_sum = $signed({{4{l2abc6_r[63]}}, l2abc6_r, 16'h0})
               + $signed({{1{phi6_r[50]}}, phi6_r, 32'h0})
               + $signed({35'h0, plo6_r})
               + 84'sh8000_0000_0000;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      height7_r <= h_sum[79:48];
      slope7_r  <= slope6_r;
      curv7_r   <= curv6_r;
      lif7_r    <= lif6_r;
      lis7_r    <= lis6_r;
      rif7_r    <= rif6_r;
      ris7_r    <= ris6_r;
    end
  end

  assign out_tdata = {4'h0, ris7_r, rif7_r, lis7_r, lif7_r, curv7_r, slope7_r, height7_r};

  // ---------------------------------------------------------------- assertions
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v_r[0])
    else $error("accepted request did not enter stage 1");

  a_pos_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] |-> (p1_r <= POS_ONE))
    else $error("position above one in pipeline");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[6] && v_r[5] && !out_tready) |=> v_r[5])
    else $error("stage 6 lost an item while output stalled");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_tready) |-> !in_tready)
    else $error("request accepted into a full stalled pipeline");

endmodule

FILE: tb/sv/cbez_checker.sv
// Checker for the cubic Bezier evaluate-and-split block: predicts each result and compares.
`timescale 1ns / 100ps

module cbez_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cbez_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [cbez_pkg::HGT_W-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [cbez_pkg::IN_TD_W-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [cbez_pkg::OUT_TD_W-1:0] out_tdata,
  output int                            errors,
  output int                            results_owed
);
  import cbez_pkg::*;

  typedef struct packed {
    logic [HGT_W-1:0] height;
    logic [DER_W-1:0] slope;
    logic [DER_W-1:0] curvature;
    logic [HGT_W-1:0] left_first;
    logic [HGT_W-1:0] left_second;
    logic [HGT_W-1:0] right_first;
    logic [HGT_W-1:0] right_second;
  } curve_result_t;

  logic [HGT_W-1:0] ctl [4];   // shadow of the control heights
  curve_result_t    owed_results [$];
  int               served;

  // floor(v / 2^s + 1/2)
  function automatic logic signed [127:0] round_off(input logic signed [127:0] v, input int s);
    return (v + (128'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic curve_result_t eval_split(input pos_t pos);
    logic signed [127:0] a, b, c, d, p, q, acc;
    curve_result_t       r;
    a = 128'($signed(ctl[REG_START_HEIGHT]));
    b = 128'($signed(ctl[REG_FIRST_CONTROL]));
    c = 128'($signed(ctl[REG_SECOND_CONTROL]));
    d = 128'($signed(ctl[REG_END_HEIGHT]));
    p = 128'((pos > POS_ONE) ? POS_ONE : pos);
    q = 128'(POS_ONE) - p;
    acc = a*q*q*q + 3*b*p*q*q + 3*c*p*p*q + d*p*p*p;
    r.height = HGT_W'(round_off(acc, 48));
    acc = 3 * ((b - a)*q*q + 2*(c - b)*p*q + (d - c)*p*p);
    r.slope = DER_W'(round_off(acc, 32));
    acc = 6 * ((a - 2*b + c)*q + (b - 2*c + d)*p);
    r.curvature = DER_W'(round_off(acc, 16));
    r.left_first   = HGT_W'(round_off(a*q + b*p, 16));
    r.left_second  = HGT_W'(round_off(a*q*q + 2*b*p*q + c*p*p, 32));
    r.right_first  = HGT_W'(round_off(b*q*q + 2*c*p*q + d*p*p, 32));
    r.right_second = HGT_W'(round_off(c*q + d*p, 16));
    return r;
  endfunction

  task automatic flag_error(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("%0t: result %0d %0s: got %0h, predicted %0h", $time, served, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      flag_error(what, got, want);
  endtask

  always @(posedge clk) begin
    curve_result_t want;
    if (!rst_n) begin
      owed_results.delete();
      ctl <= '{default: '0};
    end else begin
      if (cfg_we)
        ctl[cfg_addr] <= cfg_wdata;
      if (in_tvalid && in_tready)
        owed_results.insert(owed_results.size(), eval_split(in_tdata[POS_W-1:0]));
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          flag_error("unrequested result", out_tdata[63:0], '0);
        end else begin
          want = owed_results.pop_front();
          check_field("height",       64'(out_tdata[31:0]),    64'(want.height));
          check_field("slope",        64'(out_tdata[69:32]),   64'(want.slope));
          check_field("curvature",    64'(out_tdata[107:70]),  64'(want.curvature));
          check_field("left_first",   64'(out_tdata[139:108]), 64'(want.left_first));
          check_field("left_second",  64'(out_tdata[171:140]), 64'(want.left_second));
          check_field("right_first",  64'(out_tdata[203:172]), 64'(want.right_first));
          check_field("right_second", 64'(out_tdata[235:204]), 64'(want.right_second));
        end
        served++;
      end
    end
    results_owed <= owed_results.size();
  end

endmodule

FILE: tb/sv/tb_cubic_bezier_eval_and_split.sv
// Top of the cubic Bezier evaluate-and-split testbench: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_cubic_bezier_eval_and_split;
  import cbez_pkg::*;

  // run is cut off here
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 144;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr   = '0;
  logic [HGT_W-1:0]    cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_TD_W-1:0]  in_tdata   = '0;   // [16:0] position, [23:17] zero
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_TD_W-1:0] out_tdata;         // height, slope, curvature, left/right inner points

  int errors;
  int results_owed;
  int cycles;
  bit quiet;        // no idling on either side while set
  int stall_reqs;   // bumped by stimulus to ask the receiver for a long hold-off
  int stall_done;
  int hold_left;

  cubic_bezier_eval_and_split dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  cbez_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .errors       (errors),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request so the
  // pipeline fills and in_tready drops
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      stall_done <= 0;
    end else if (stall_done != stall_reqs) begin
      stall_done <= stall_reqs;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  // one request; valid stays high afterwards so back-to-back requests keep it up
  task automatic send_position(input pos_t pos);
    while (!quiet && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TD_W'(pos);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [HGT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_heights(input logic [HGT_W-1:0] h [4]);
    write_reg(REG_START_HEIGHT,   h[0]);
    write_reg(REG_FIRST_CONTROL,  h[1]);
    write_reg(REG_SECOND_CONTROL, h[2]);
    write_reg(REG_END_HEIGHT,     h[3]);
    cfg_we <= 1'b0;
  endtask

  // extremes, small values around zero, or anything
  function automatic logic [HGT_W-1:0] rand_height();
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return HGT_W'($urandom_range(2097151) - 32'd1048576);
      default: return $urandom();
    endcase
  endfunction

  // mostly legal positions, weighted toward both ends, some above one
  function automatic pos_t rand_position();
    case ($urandom_range(9))
      0:       return pos_t'($urandom_range(16));
      1:       return POS_ONE - pos_t'($urandom_range(16));
      2, 3:    return pos_t'($urandom_range(131071));
      default: return pos_t'($urandom_range(65536));
    endcase
  endfunction

  initial begin
    pos_t             corners [9];
    logic [HGT_W-1:0] h [4];
    corners = '{17'h00000, 17'h00001, 17'h08000, 17'h0AAAA, 17'h0FFFF,
                17'h10000, 17'h10001, 17'h15555, 17'h1FFFF};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: every output must be zero
    send_position(17'h00000);
    send_position(POS_ONE);
    send_position(17'h1FFFF);
    drain();

    // widest control differences, both signs, at the corner positions
    h = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    load_heights(h);
    foreach (corners[i]) send_position(corners[i]);
    drain();
    h = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    load_heights(h);
    foreach (corners[i]) send_position(corners[i]);
    drain();

    // random phases, one register setting each
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       h = '{default: 32'h7FFF_FFFF};
        1:       h = '{default: 32'h8000_0000};
        3:       h = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        4:       foreach (h[k]) h[k] = HGT_W'($urandom_range(2097151) - 32'd1048576);
        default: foreach (h[k]) h[k] = (phase == 2) ? $urandom() : rand_height();
      endcase
      load_heights(h);
      quiet <= (phase == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 3 && i == 40)
          stall_reqs <= stall_reqs + 1;   // sender keeps offering through the hold-off
        if (phase == 6 && i == 70)
          drain();                        // sender pauses until the pipe is empty
        send_position(rand_position());
      end
      drain();
      quiet <= 1'b0;
    end

    // let any stray result show up before the verdict
    repeat (12) @(posedge clk);
    if (errors == 0 && results_owed == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
